/* hdl/acfc_pkg.sv */
// Shared types, widths, codes and helpers for the box-versus-plane culling block.
package acfc_pkg;

    localparam int COORD_W      = 32;
    localparam int OP_W         = 2;
    localparam int PLANE_IDX_W  = 3;
    localparam int CFG_W        = 4;
    localparam int IN_TDATA_W   = 328;
    localparam int OUT_TDATA_W  = 8;
    localparam int PROD_W       = 2 * COORD_W;
    // three full products plus the scaled offset never leave 66 signed bits
    localparam int ACC_W        = PROD_W + 2;

    localparam int MAX_PLANES_DEF = 8;

    localparam logic [CFG_W-1:0] PLANE_COUNT_RST = 4'd6;

    // multiplying the offset by this yields -(offset << 16)
    localparam logic [COORD_W-1:0] OFFSET_SCALE_NEG = 32'hFFFF_0000;

    localparam logic [OP_W-1:0] OP_STORE    = 2'd0;
    localparam logic [OP_W-1:0] OP_FRUSTUM  = 2'd1;
    localparam logic [OP_W-1:0] OP_STRADDLE = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] offset;
        logic [COORD_W-1:0] n_z;
        logic [COORD_W-1:0] n_y;
        logic [COORD_W-1:0] n_x;
    } t_plane;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
    } t_mac_req;

    // far corner takes max where the normal is non-negative, near corner the opposite
    function automatic logic [COORD_W-1:0] pick_corner(
        input logic [COORD_W-1:0] n,
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W-1:0] hi,
        input logic               far_side
    );
        logic take_max;
        begin
            take_max = far_side ^ n[COORD_W-1];
            return take_max ? hi : lo;
        end
    endfunction

endpackage

/* hdl/acfc_plane_mem.sv */
// Plane slot memory: one write port, one registered read port.
module acfc_plane_mem
    import acfc_pkg::*;
#(
    parameter int DEPTH = MAX_PLANES_DEF,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_plane        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_plane        o_rd_data
);

    t_plane r_mem [DEPTH];
    t_plane r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/acfc_mac.sv */
// Shared signed multiply-accumulate: registered product, then exact wide accumulate.
module acfc_mac
    import acfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mac_req         i_req,
    output logic [ACC_W-1:0] o_acc
);

    logic                     r_prod_valid;
    logic                     r_prod_first;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_prod;
    logic        [ACC_W-1:0]  r_acc;
    logic        [ACC_W-1:0]  w_prod_ext;
    logic        [ACC_W-1:0]  w_base;

    assign w_prod = $signed(i_req.a) * $signed(i_req.b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_prod_first <= 1'b0;
        end else begin
            r_prod_valid <= i_req.valid;
            r_prod_first <= i_req.first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    // restart the sum on the first term of a plane
    assign w_base     = r_prod_first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (r_prod_valid) begin
            r_acc <= w_base + w_prod_ext;
        end
    end

    assign o_acc = r_acc;

endmodule

/* hdl/aabb_plane_frustum_cull.sv */
// Top level of the box-versus-plane culling block: stream ports, sequencer, plane slots.
//
// Culls axis-aligned boxes (signed Q16.16) against planes. Op 0 writes the word's plane into
// slot plane_index (slots at or above MAX_PLANES are dropped) and answers hit = 0. Op 1 tests
// the box against slots 0 .. plane_count-1 (plane_count saturates at MAX_PLANES, zero answers
// hit = 1) using the far corner of each plane, and answers 0 at the first plane that puts that
// corner behind it. Op 2 answers 1 when the box straddles or touches the word's own plane.
// Op 3 answers 0. Every input word yields exactly one output word with hit in bit 0.
// Distances are exact: three 32x32 products less the offset scaled by 2^16, summed in 66 bits.
// All arithmetic runs through one multiply-accumulate unit, one term per cycle: a plane issues
// four terms, WAIT drains the product and accumulate stages and EVAL reads the sign. Op 1 reads
// one slot per plane visited; op 2 adds a near-corner pass unless the far pass answers 0.
// cfg_ready is always high. s_axis_tready is high only while the sequencer is idle; a finished
// result waits in the output register, so the next word can be taken while the previous result
// is still stalled. Slots must be written before a frustum test reads them. plane_count is to
// be written on the cfg channel only while the block is idle; the block does not enforce this.
module aabb_plane_frustum_cull
    import acfc_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // plane_count write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // plane_index, normal_x, normal_y, normal_z, plane_offset,
    // min_x, min_y, min_z, max_x, max_y, max_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [OP_W-1:0]        s_axis_tuser,
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW        = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W     = $clog2(MAX_PLANES + 1);
    localparam int IDX_CMP_W = ((AW > PLANE_IDX_W) ? AW : PLANE_IDX_W) + 1;
    localparam int CNT_CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // unpack the input word
    logic [PLANE_IDX_W-1:0] w_plane_index;
    t_plane                 w_in_plane;
    logic [COORD_W-1:0]     w_in_min [3];
    logic [COORD_W-1:0]     w_in_max [3];

    assign w_plane_index     = s_axis_tdata[2:0];
    assign w_in_plane.n_x    = s_axis_tdata[34:3];
    assign w_in_plane.n_y    = s_axis_tdata[66:35];
    assign w_in_plane.n_z    = s_axis_tdata[98:67];
    assign w_in_plane.offset = s_axis_tdata[130:99];
    assign w_in_min[0]       = s_axis_tdata[162:131];
    assign w_in_min[1]       = s_axis_tdata[194:163];
    assign w_in_min[2]       = s_axis_tdata[226:195];
    assign w_in_max[0]       = s_axis_tdata[258:227];
    assign w_in_max[1]       = s_axis_tdata[290:259];
    assign w_in_max[2]       = s_axis_tdata[322:291];

    // control state
    logic [2:0]       r_state, n_state;
    logic [1:0]       r_k, n_k;
    logic [CNT_W-1:0] r_pidx, n_pidx;
    logic             r_far, n_far;
    logic             r_res, n_res;
    logic [OP_W-1:0]  r_op, n_op;
    logic [CFG_W-1:0] r_plane_count;
    logic             r_out_valid, n_out_valid;
    logic             r_hit, n_hit;

    // payload held for the whole item
    t_plane             r_item_plane;
    logic [COORD_W-1:0] r_min [3];
    logic [COORD_W-1:0] r_max [3];

    logic                 w_accept;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_lim;
    logic [IDX_CMP_W-1:0] w_pidx_ext;
    logic                 w_store_ok;
    t_plane               w_mem_rd;
    t_plane               w_plane;
    logic [COORD_W-1:0]   w_corner [3];
    t_mac_req             w_mac_req;
    logic [ACC_W-1:0]     w_acc;
    logic                 w_neg;
    logic                 w_zero;
    logic                 w_last_plane;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_lim = (CNT_CMP_W'(r_plane_count) > CNT_CMP_W'(MAX_PLANES)) ?
                   CNT_W'(MAX_PLANES) : CNT_W'(r_plane_count);

    assign w_pidx_ext = IDX_CMP_W'(w_plane_index);
    assign w_store_ok = w_pidx_ext < IDX_CMP_W'(MAX_PLANES);

    acfc_plane_mem #(
        .DEPTH (MAX_PLANES),
        .AW    (AW)
    ) u_plane_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (s_axis_tuser == OP_STORE) && w_store_ok),
        .i_wr_addr (w_pidx_ext[AW-1:0]),
        .i_wr_data (w_in_plane),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (r_pidx[AW-1:0]),
        .o_rd_data (w_mem_rd)
    );

    // frustum test walks the slots, straddle test uses the word's own plane
    assign w_plane = (r_op == OP_FRUSTUM) ? w_mem_rd : r_item_plane;

    assign w_corner[0] = pick_corner(w_plane.n_x, r_min[0], r_max[0], r_far);
    assign w_corner[1] = pick_corner(w_plane.n_y, r_min[1], r_max[1], r_far);
    assign w_corner[2] = pick_corner(w_plane.n_z, r_min[2], r_max[2], r_far);

    // one term per cycle into the shared multiply-accumulate
    always_comb begin
        w_mac_req.valid = (r_state == ST_ISSUE);
        w_mac_req.first = (r_k == 2'd0);
        unique case (r_k)
            2'd0: begin
                w_mac_req.a = w_plane.n_x;
                w_mac_req.b = w_corner[0];
            end
            2'd1: begin
                w_mac_req.a = w_plane.n_y;
                w_mac_req.b = w_corner[1];
            end
            2'd2: begin
                w_mac_req.a = w_plane.n_z;
                w_mac_req.b = w_corner[2];
            end
            default: begin
                w_mac_req.a = w_plane.offset;
                w_mac_req.b = OFFSET_SCALE_NEG;
            end
        endcase
    end

    acfc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .o_acc   (w_acc)
    );

    assign w_neg        = w_acc[ACC_W-1];
    assign w_zero       = (w_acc == '0);
    assign w_last_plane = (CNT_W'(r_pidx + 1'b1) == w_lim);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_pidx      = r_pidx;
        n_far       = r_far;
        n_res       = r_res;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        n_hit       = r_hit;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op   = s_axis_tuser;
                    n_far  = 1'b1;
                    n_pidx = '0;
                    n_k    = '0;
                    n_res  = 1'b0;
                    n_state = ST_DONE;
                    if (s_axis_tuser == OP_FRUSTUM) begin
                        if (w_lim == '0) begin
                            n_res = 1'b1;
                        end else begin
                            n_state = ST_READ;
                        end
                    end else if (s_axis_tuser == OP_STRADDLE) begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_READ: begin
                n_k     = '0;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_DONE;
                if (r_op == OP_FRUSTUM) begin
                    if (w_neg) begin
                        n_res = 1'b0;
                    end else if (w_last_plane) begin
                        n_res = 1'b1;
                    end else begin
                        n_pidx  = r_pidx + 1'b1;
                        n_state = ST_READ;
                    end
                end else if (r_far) begin
                    // far corner behind the plane: no straddle, skip the near pass
                    if (w_neg) begin
                        n_res = 1'b0;
                    end else begin
                        n_far   = 1'b0;
                        n_k     = '0;
                        n_state = ST_ISSUE;
                    end
                end else begin
                    n_res = w_neg || w_zero;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_hit       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_k           <= '0;
            r_pidx        <= '0;
            r_far         <= 1'b1;
            r_res         <= 1'b0;
            r_op          <= OP_STORE;
            r_out_valid   <= 1'b0;
            r_hit         <= 1'b0;
            r_plane_count <= PLANE_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_pidx      <= n_pidx;
            r_far       <= n_far;
            r_res       <= n_res;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
            if (i_cfg_valid) begin
                r_plane_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item_plane <= w_in_plane;
            r_min        <= w_in_min;
            r_max        <= w_in_max;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_hit};

endmodule

/* hdl/acfc_checker.sv */
// Port-level checks for the culling block, bound onto the top level.
module acfc_checker
    import acfc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // an accepted word takes the sequencer out of idle, which drops the input ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after an accept");

    // idle with the last result taken: no result may appear without a new word
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result word without an input word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed or dropped");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("result pad bits not zero");

endmodule

bind aabb_plane_frustum_cull acfc_checker u_acfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
